>>> rtl/core/linear_interp_resampler_assert.svh
// ---------------------------------------------------------------------------
// linear_interp_resampler_assert.svh
// Assertion macros used by the resampler top level. They expect clk_i and rst_ni
// in scope.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define LIRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LIRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lirs_pkg.sv
// ---------------------------------------------------------------------------
// lirs_pkg
// Shared widths, constants and control structs of the linear resampler.
// ---------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 18;
  // Phase remainder can reach dest + source - 1 right after a group.
  localparam int REM_W       = RATE_W + 1;
  localparam int MAX_RESULTS = 16;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd16000;
  localparam logic [RATE_W-1:0] DEST_RATE_RST   = 18'd48000;

  // Register indexes on the config port.
  localparam logic REG_SOURCE_RATE = 1'b0;
  localparam logic REG_DEST_RATE   = 1'b1;

  // Divider command: whole = remainder / dest, else fraction.
  typedef struct packed {
    logic start;
    logic whole;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lirs_div.sv
// ---------------------------------------------------------------------------
// lirs_div
// Shared restoring divider, one quotient bit per cycle. Whole mode gives
// rem / den; fraction mode gives (rem << FRAC_BITS) / den with rem < den.
// ---------------------------------------------------------------------------
`default_nettype none

module lirs_div
  import lirs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire div_ctrl_t            ctrl_i,
  input  wire logic [REM_W-1:0]     rem_i,
  input  wire logic [RATE_W-1:0]    den_i,
  output div_stat_t                 stat_o,
  output logic      [REM_W-1:0]     quo_whole_o,
  output logic      [FRAC_BITS-1:0] frac_o,
  output logic      [RATE_W-1:0]    rem_o
);

  localparam int NW    = (FRAC_BITS > REM_W) ? FRAC_BITS : REM_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RATE_W-1:0] r_q, r_d, den_q;
  logic [NW-1:0]    num_q, quo_q;
  logic [RATE_W:0]  trial, diff;
  logic             ge;

  assign trial = {r_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign r_d   = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.whole ? CNT_W'(REM_W) : CNT_W'(FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      r_q   <= ctrl_i.whole ? '0 : rem_i[RATE_W-1:0];
      num_q <= ctrl_i.whole ? (NW'(rem_i) << (NW - REM_W)) : '0;
      quo_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      r_q   <= r_d;
      num_q <= num_q << 1;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_whole_o = quo_q[REM_W-1:0];
  assign frac_o      = quo_q[FRAC_BITS-1:0];
  assign rem_o       = r_q;

endmodule

`default_nettype wire

>>> rtl/core/lirs_interp.sv
// ---------------------------------------------------------------------------
// lirs_interp
// Interpolation datapath: registered (s1-s0)*frac, then floor shift and add.
// ---------------------------------------------------------------------------
`default_nettype none

module lirs_interp
  import lirs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       mul_en_i,
  input  wire logic                       add_en_i,
  input  wire logic signed [SAMPLE_W-1:0] s0_i,
  input  wire logic signed [SAMPLE_W-1:0] s1_i,
  input  wire logic        [FRAC_BITS-1:0] frac_i,
  output logic signed      [SAMPLE_W-1:0] result_o
);

  localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_W+1:0] step, sum;

  assign diff = (SAMPLE_W + 1)'(s1_i) - (SAMPLE_W + 1)'(s0_i);
  // Arithmetic shift gives the floor of the scaled product.
  assign step = prod_q[PROD_W-1:FRAC_BITS];
  assign sum  = (SAMPLE_W + 2)'(s0_i) + step;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      // Both operands sign-extended to full product width.
      prod_q <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac_i}));
    end
    if (add_en_i) begin
      result_o <= sum[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/linear_interp_resampler.sv
// ---------------------------------------------------------------------------
// linear_interp_resampler
// Linear-interpolation sample-rate converter for signed 16-bit PCM runs.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: in_sample, tlast: is_final
//   m_axis    out        m_axis_tvalid/tready      tdata: out_sample, tlast: end_of_run
//   cfg       in         cfg_valid_i/cfg_ready_o   cfg_addr_i: index, cfg_data_i: rate
//
// One request may run up to two whole-part divisions and one fraction division
// for every output it yields, and also waits for any time m_axis_tready stays
// low. The bit-serial divider sets most of a request's duration.
// s_axis_tready is high only when the sequencer is idle; a result is held on
// m_axis until taken and the sequencer waits meanwhile.
// Reset clears the rates to 16000/48000 and the run state; no clearing pass.
// Config writes are always taken and apply from the next input request.
// ---------------------------------------------------------------------------
`default_nettype none

`include "linear_interp_resampler_assert.svh"

module linear_interp_resampler
  import lirs_pkg::*;
#(
  parameter int MAX_UPSAMPLE = 8,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_addr_i,
  input  wire logic [RATE_W-1:0]   cfg_data_i,
  // input samples
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] in_sample
  input  wire logic                s_axis_tlast,   // is_final
  // output samples
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] out_sample
  output logic                     m_axis_tlast    // end_of_run
);

  localparam int LIM_W = RATE_W + $clog2(MAX_UPSAMPLE + 1);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_REDUCE    = 13'b0000000000010,
    ST_DIVQ_PRE  = 13'b0000000000100,
    ST_SKIP      = 13'b0000000001000,
    ST_EMIT      = 13'b0000000010000,
    ST_DIVF      = 13'b0000000100000,
    ST_ADD       = 13'b0000001000000,
    ST_OUT       = 13'b0000010000000,
    ST_ADV       = 13'b0000100000000,
    ST_DIVQ_POST = 13'b0001000000000,
    ST_TAIL      = 13'b0010000000000,
    ST_FLUSH     = 13'b0100000000000,
    ST_END       = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [RATE_W-1:0] source_rate_q, dest_rate_q;

  // Run state
  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [RATE_W-1:0]   skip_q, skip_d;
  logic                have_q, have_d;

  // Per-request working registers
  logic [SAMPLE_W-1:0] x_q, x_d;
  logic                fin_q, fin_d;
  logic [RATE_W-1:0]   src_q, src_d, dst_q, dst_d;
  logic [N_W-1:0]      n_q, n_d;
  logic                pend_q, pend_d;    // computed output not yet shown
  logic                tail_q, tail_d;    // trailing group at the last sample
  logic                final_q, final_d;  // shown output closes the request

  // Effective rates: zero reads as one, dest clamped to MAX_UPSAMPLE*source
  logic [RATE_W-1:0] src_eff, dst_raw, dst_eff;
  logic [LIM_W-1:0]  lim;

  assign src_eff = (source_rate_q == '0) ? RATE_W'(1) : source_rate_q;
  assign dst_raw = (dest_rate_q == '0) ? RATE_W'(1) : dest_rate_q;
  assign lim     = LIM_W'(src_eff) * LIM_W'(MAX_UPSAMPLE);
  assign dst_eff = (LIM_W'(dst_raw) > lim) ? lim[RATE_W-1:0] : dst_raw;

  logic [REM_W:0] rem_plus;
  logic           emit_ok;

  assign rem_plus = {1'b0, rem_q} + (REM_W + 1)'(src_q);
  assign emit_ok  = (n_q != N_W'(MAX_RESULTS)) &&
                    (tail_q ? (rem_plus <= (REM_W + 1)'(dst_q))
                            : (rem_q < REM_W'(dst_q)));

  // Shared divider and interpolation datapath
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [REM_W-1:0]      div_quo;
  logic [FRAC_BITS-1:0]  div_frac;
  logic [RATE_W-1:0]     div_rem;
  logic                  mul_en, add_en;
  logic [SAMPLE_W-1:0]   s1;
  logic [SAMPLE_W-1:0]   result;

  lirs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .rem_i       (rem_q),
    .den_i       (dst_q),
    .stat_o      (div_stat),
    .quo_whole_o (div_quo),
    .frac_o      (div_frac),
    .rem_o       (div_rem)
  );

  // In the trailing group prev_q already holds the last sample and s1 is zero.
  assign s1 = tail_q ? '0 : x_q;

  lirs_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .add_en_i (add_en),
    .s0_i     (prev_q),
    .s1_i     (s1),
    .frac_i   (div_frac),
    .result_o (result)
  );

  // Config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_rate_q <= SOURCE_RATE_RST;
      dest_rate_q   <= DEST_RATE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_SOURCE_RATE: source_rate_q <= cfg_data_i;
        REG_DEST_RATE:   dest_rate_q   <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    prev_d   = prev_q;
    rem_d    = rem_q;
    skip_d   = skip_q;
    have_d   = have_q;
    x_d      = x_q;
    fin_d    = fin_q;
    src_d    = src_q;
    dst_d    = dst_q;
    n_d      = n_q;
    pend_d   = pend_q;
    tail_d   = tail_q;
    final_d  = final_q;
    div_ctrl = '0;
    mul_en   = 1'b0;
    add_en   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          x_d     = s_axis_tdata;
          fin_d   = s_axis_tlast;
          src_d   = src_eff;
          dst_d   = dst_eff;
          n_d     = '0;
          pend_d  = 1'b0;
          tail_d  = 1'b0;
          state_d = have_q ? ST_REDUCE : ST_TAIL;
        end
      end
      // Fold a remainder left over from a rate change into the skip count.
      ST_REDUCE: begin
        if (rem_q >= REM_W'(dst_q)) begin
          div_ctrl.start = 1'b1;
          div_ctrl.whole = 1'b1;
          state_d        = ST_DIVQ_PRE;
        end else begin
          state_d = ST_SKIP;
        end
      end
      ST_DIVQ_PRE: begin
        if (div_stat.done) begin
          rem_d   = REM_W'(div_rem);
          skip_d  = skip_q + div_quo[RATE_W-1:0];
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip_q != '0) begin
          skip_d  = skip_q - 1'b1;
          state_d = ST_TAIL;
        end else begin
          tail_d  = 1'b0;
          state_d = ST_EMIT;
        end
      end
      // Show a pending output only once another is known to follow, so the
      // last one of the request can carry end_of_run.
      ST_EMIT: begin
        if (emit_ok) begin
          if (pend_q) begin
            final_d = 1'b0;
            state_d = ST_OUT;
          end else begin
            div_ctrl.start = 1'b1;
            div_ctrl.whole = 1'b0;
            state_d        = ST_DIVF;
          end
        end else begin
          state_d = tail_q ? ST_FLUSH : ST_ADV;
        end
      end
      ST_DIVF: begin
        if (div_stat.done) begin
          mul_en  = 1'b1;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        add_en  = 1'b1;
        pend_d  = 1'b1;
        n_d     = n_q + 1'b1;
        rem_d   = rem_plus[REM_W-1:0];
        state_d = ST_EMIT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          pend_d  = 1'b0;
          state_d = final_q ? ST_END : ST_EMIT;
        end
      end
      // Outputs dropped by the cap still move the phase.
      ST_ADV: begin
        if (rem_q < REM_W'(dst_q)) begin
          rem_d = rem_plus[REM_W-1:0];
        end else begin
          div_ctrl.start = 1'b1;
          div_ctrl.whole = 1'b1;
          state_d        = ST_DIVQ_POST;
        end
      end
      ST_DIVQ_POST: begin
        if (div_stat.done) begin
          rem_d   = REM_W'(div_rem);
          skip_d  = div_quo[RATE_W-1:0] - 1'b1;
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        prev_d = x_q;
        have_d = 1'b1;
        if (fin_q && (skip_q == '0)) begin
          tail_d  = 1'b1;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_q) begin
          final_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (fin_q) begin
          prev_d = '0;
          rem_d  = '0;
          skip_d = '0;
          have_d = 1'b0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q  <= '0;
      rem_q   <= '0;
      skip_q  <= '0;
      have_q  <= 1'b0;
      fin_q   <= 1'b0;
      n_q     <= '0;
      pend_q  <= 1'b0;
      tail_q  <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      rem_q   <= rem_d;
      skip_q  <= skip_d;
      have_q  <= have_d;
      fin_q   <= fin_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
      tail_q  <= tail_d;
      final_q <= final_d;
    end
  end

  // Payload of the current request
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    src_q <= src_d;
    dst_q <= dst_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = result;
  assign m_axis_tlast  = final_q & fin_q;

  // Assertions
  `LIRS_ASSERT_NOW(a_in_out_excl, s_axis_tready, !m_axis_tvalid, "input taken while output shown")
  `LIRS_ASSERT_NOW(a_div_free, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
  `LIRS_ASSERT_NOW(a_out_counted, m_axis_tvalid, n_q != '0, "output shown before any computed")
  `LIRS_ASSERT_NOW(a_rem_reduced, (state_q == ST_IDLE) && have_q, rem_q < REM_W'(dst_q), "stored remainder not reduced")
  `LIRS_ASSERT_NOW(a_run_clear, !have_q, (skip_q == '0) && (rem_q == '0), "run state left over after run end")
  `LIRS_ASSERT_NEXT(a_last_ends, m_axis_tvalid && m_axis_tready && m_axis_tlast, state_q == ST_END, "end_of_run not closing the run")

endmodule

`default_nettype wire
